### hdl/pthc_pkg.sv
`timescale 1ns / 1ps
// Package for the pressure/temperature/humidity compensation core.
// Holds the beat and coefficient types, sequencer codes and fixed constants.
// It has no dependencies.
package pthc_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_q24_8;
      logic               pressure_valid;
      logic [16:0]        humidity_q22_10;
   } rsp_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [15:0] h4;
      logic [15:0] h5;
      logic [7:0]  h6;
   } cfg_type;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [2:0] CSR_TEMP = 3'd0;
   localparam logic [2:0] CSR_PRESS_LOW = 3'd1;
   localparam logic [2:0] CSR_PRESS_HIGH = 3'd2;
   localparam logic [2:0] CSR_PRESS_NINE = 3'd3;
   localparam logic [2:0] CSR_HUM_LOW = 3'd4;
   localparam logic [2:0] CSR_HUM_HIGH = 3'd5;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ISSUE,
      BK_MUL,
      BK_DIV,
      BK_PUSH
   } bk_state_type;

   typedef enum logic [4:0] {
      T_V1, T_DD, T_V2,
      P_XX, P_W2A, P_W2B, P_W1A, P_W1B, P_W1C, P_NUM, P_A1, P_A2, P_B,
      H_A, H_B, H_C, H_E, H_F, H_V, H_S, H_R
   } step_type;

   localparam logic [63:0] PRESS_T_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_RAW_BASE = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE = 64'd3125;
   localparam logic [63:0] PRESS_W1_BIAS = 64'h0000_8000_0000_0000;
   localparam logic [31:0] HUM_T_OFFSET = 32'd76800;
   localparam logic [31:0] HUM_LIMIT = 32'd419430400;
   localparam logic [31:0] HUM_ROUND_A = 32'd16384;
   localparam logic [31:0] HUM_BIAS_E = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_F = 32'd8192;
   localparam logic [31:0] HUM_BIAS_C = 32'd32768;
   localparam logic [31:0] TEMP_ROUND = 32'd128;

   function automatic logic [63:0] sx16_64(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32_64(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] sx16_32(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

### hdl/pthc_mul.sv
`timescale 1ns / 1ps
// Shared multiplier: low 64 bits of a 64 x 64 product from one 32 x 32 multiplier.
// Three partial products are summed in turn; it has no package dependencies.
module pthc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_a, mul_b;

   always_comb begin
      mul_a = (phase_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      mul_b = (phase_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      phase_in = phase_ff;
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         phase_in = 2'd0;
         a_in = op_a;
         b_in = op_b;
      end else if (busy_ff) begin
         prod_in = mul_a * mul_b;
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            2'd3: begin
               acc_in = acc_ff + {prod_ff[31:0], 32'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         phase_ff <= phase_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign result = acc_ff;

endmodule

### hdl/pthc_div.sv
`timescale 1ns / 1ps
// Signed 64-bit divider truncating toward zero, one quotient bit per cycle.
// Restoring loop on magnitudes; no package dependencies.
module pthc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [5:0]  count_ff, count_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      count_in = count_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in = dividend[63] ^ divisor[63];
         quo_in = dividend[63] ? (64'd0 - dividend) : dividend;
         den_in = divisor[63] ? (64'd0 - divisor) : divisor;
         rem_in = 64'd0;
         count_in = 6'd0;
      end else if (busy_ff) begin
         count_in = count_ff + 6'd1;
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      count_ff <= count_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (64'd0 - quo_ff) : quo_ff;

endmodule

### hdl/pthc_front.sv
`timescale 1ns / 1ps
// Front end: calibration registers and a two-entry queue of accepted sample beats.
// Depends on pthc_pkg.
module pthc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pthc_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [pthc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pthc_pkg::CSR_DATA_W-1:0]    csr_data,
   output pthc_pkg::cfg_type                  cfg,
   output logic                               item_valid,
   output pthc_pkg::req_type                  item_data,
   input  logic                               item_pop
);

   logic [47:0] temp_ff, temp_in;
   logic [63:0] plow_ff, plow_in;
   logic [63:0] phigh_ff, phigh_in;
   logic [15:0] pnine_ff, pnine_in;
   logic [31:0] hlow_ff, hlow_in;
   logic [39:0] hhigh_ff, hhigh_in;

   pthc_pkg::req_type queue_ff [2];
   pthc_pkg::req_type queue_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   always_comb begin
      temp_in = temp_ff;
      plow_in = plow_ff;
      phigh_in = phigh_ff;
      pnine_in = pnine_ff;
      hlow_in = hlow_ff;
      hhigh_in = hhigh_ff;
      if (csr_we) begin
         case (csr_index)
            pthc_pkg::CSR_TEMP:       temp_in = csr_data[47:0];
            pthc_pkg::CSR_PRESS_LOW:  plow_in = csr_data;
            pthc_pkg::CSR_PRESS_HIGH: phigh_in = csr_data;
            pthc_pkg::CSR_PRESS_NINE: pnine_in = csr_data[15:0];
            pthc_pkg::CSR_HUM_LOW:    hlow_in = csr_data[31:0];
            pthc_pkg::CSR_HUM_HIGH:   hhigh_in = csr_data[39:0];
            default:                  temp_in = temp_ff;
         endcase
      end
   end

   always_comb begin
      cfg.t1 = temp_ff[15:0];
      cfg.t2 = temp_ff[31:16];
      cfg.t3 = temp_ff[47:32];
      cfg.p1 = plow_ff[15:0];
      cfg.p2 = plow_ff[31:16];
      cfg.p3 = plow_ff[47:32];
      cfg.p4 = plow_ff[63:48];
      cfg.p5 = phigh_ff[15:0];
      cfg.p6 = phigh_ff[31:16];
      cfg.p7 = phigh_ff[47:32];
      cfg.p8 = phigh_ff[63:48];
      cfg.p9 = pnine_ff;
      cfg.h1 = hlow_ff[7:0];
      cfg.h2 = hlow_ff[23:8];
      cfg.h3 = hlow_ff[31:24];
      cfg.h4 = hhigh_ff[15:0];
      cfg.h5 = hhigh_ff[31:16];
      cfg.h6 = hhigh_ff[39:32];
   end

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = item_pop && (count_ff != 2'd0);
   assign item_valid = (count_ff != 2'd0);
   assign item_data = queue_ff[rd_ptr_ff];

   always_comb begin
      queue_in = queue_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         queue_in[wr_ptr_ff] = req_data;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         plow_ff <= '0;
         phigh_ff <= '0;
         pnine_ff <= '0;
         hlow_ff <= '0;
         hhigh_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         temp_ff <= temp_in;
         plow_ff <= plow_in;
         phigh_ff <= phigh_in;
         pnine_ff <= pnine_in;
         hlow_ff <= hlow_in;
         hhigh_ff <= hhigh_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      queue_ff <= queue_in;
   end

endmodule

### hdl/pthc_back.sv
`timescale 1ns / 1ps
// Back end: sequencer that evaluates the compensation formulas on the shared
// multiplier and divider and holds the result beat. Depends on pthc_pkg.
module pthc_back (
   input  logic               clock,
   input  logic               reset,
   input  pthc_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  pthc_pkg::req_type  item_data,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pthc_pkg::rsp_type  rsp_data
);

   pthc_pkg::bk_state_type state_ff, state_in;
   pthc_pkg::step_type     step_ff, step_in;
   pthc_pkg::req_type      item_ff, item_in;
   pthc_pkg::rsp_type      rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] v1_ff, v1_in, dd_ff, dd_in, tf_ff, tf_in;
   logic [63:0] xx_ff, xx_in, w2_ff, w2_in, w1_ff, w1_in;
   logic [63:0] pp_ff, pp_in, sq_ff, sq_in, pa_ff, pa_in, pb_ff, pb_in;
   logic        pv_ff, pv_in;
   logic [31:0] ha_ff, ha_in, hb_ff, hb_in, hc_ff, hc_in, he_ff, he_in;
   logic [31:0] hf_ff, hf_in, hv_ff, hv_in, hs_ff, hs_in;

   logic        mul_start, mul_done, div_start, div_done;
   logic [63:0] mul_a, mul_b, mul_res, div_q;
   logic [31:0] m32;
   logic [63:0] x64, p_raw, w1_new, psum, pfin;
   logic [31:0] hx, hs_op, tc, hclamp;
   logic        out_free;

   pthc_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .result(mul_res)
   );

   pthc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(mul_res),
      .divisor(w1_ff), .done(div_done), .quotient(div_q)
   );

   assign m32 = mul_res[31:0];
   assign x64 = pthc_pkg::sx32_64(tf_ff) - pthc_pkg::PRESS_T_OFFSET;
   assign p_raw = pthc_pkg::PRESS_RAW_BASE - {44'd0, item_ff.raw_pressure};
   assign hx = tf_ff - pthc_pkg::HUM_T_OFFSET;
   assign hs_op = $signed(hv_ff) >>> 15;
   assign w1_new = $signed(mul_res) >>> 33;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mul_start = (state_ff == pthc_pkg::BK_ISSUE);
   assign div_start = (state_ff == pthc_pkg::BK_MUL) && mul_done
                      && (step_ff == pthc_pkg::P_NUM);

   always_comb begin
      case (step_ff)
         pthc_pkg::T_V1: begin
            mul_a = {32'd0, {15'd0, item_ff.raw_temperature[19:3]} - {15'd0, cfg.t1, 1'b0}};
            mul_b = pthc_pkg::sx16_64(cfg.t2);
         end
         pthc_pkg::T_DD: begin
            mul_a = {32'd0, {16'd0, item_ff.raw_temperature[19:4]} - {16'd0, cfg.t1}};
            mul_b = mul_a;
         end
         pthc_pkg::T_V2: begin
            mul_a = {32'd0, dd_ff};
            mul_b = pthc_pkg::sx16_64(cfg.t3);
         end
         pthc_pkg::P_XX: begin
            mul_a = x64;
            mul_b = x64;
         end
         pthc_pkg::P_W2A: begin
            mul_a = xx_ff;
            mul_b = pthc_pkg::sx16_64(cfg.p6);
         end
         pthc_pkg::P_W2B: begin
            mul_a = x64;
            mul_b = pthc_pkg::sx16_64(cfg.p5);
         end
         pthc_pkg::P_W1A: begin
            mul_a = xx_ff;
            mul_b = pthc_pkg::sx16_64(cfg.p3);
         end
         pthc_pkg::P_W1B: begin
            mul_a = x64;
            mul_b = pthc_pkg::sx16_64(cfg.p2);
         end
         pthc_pkg::P_W1C: begin
            mul_a = pthc_pkg::PRESS_W1_BIAS + w1_ff;
            mul_b = {48'd0, cfg.p1};
         end
         pthc_pkg::P_NUM: begin
            mul_a = {p_raw[32:0], 31'd0} - w2_ff;
            mul_b = pthc_pkg::PRESS_SCALE;
         end
         pthc_pkg::P_A1: begin
            mul_a = $signed(pp_ff) >>> 13;
            mul_b = mul_a;
         end
         pthc_pkg::P_A2: begin
            mul_a = sq_ff;
            mul_b = pthc_pkg::sx16_64(cfg.p9);
         end
         pthc_pkg::P_B: begin
            mul_a = pthc_pkg::sx16_64(cfg.p8);
            mul_b = pp_ff;
         end
         pthc_pkg::H_A: begin
            mul_a = {32'd0, pthc_pkg::sx16_32(cfg.h5)};
            mul_b = {32'd0, hx};
         end
         pthc_pkg::H_B: begin
            mul_a = {32'd0, hx};
            mul_b = {32'd0, {{24{cfg.h6[7]}}, cfg.h6}};
         end
         pthc_pkg::H_C: begin
            mul_a = {32'd0, hx};
            mul_b = {56'd0, cfg.h3};
         end
         pthc_pkg::H_E: begin
            mul_a = {32'd0, hb_ff};
            mul_b = {32'd0, hc_ff};
         end
         pthc_pkg::H_F: begin
            mul_a = {32'd0, he_ff};
            mul_b = {32'd0, pthc_pkg::sx16_32(cfg.h2)};
         end
         pthc_pkg::H_V: begin
            mul_a = {32'd0, ha_ff};
            mul_b = {32'd0, hf_ff};
         end
         pthc_pkg::H_S: begin
            mul_a = {32'd0, hs_op};
            mul_b = mul_a;
         end
         pthc_pkg::H_R: begin
            mul_a = {32'd0, hs_ff};
            mul_b = {56'd0, cfg.h1};
         end
         default: begin
            mul_a = 64'd0;
            mul_b = 64'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pthc_pkg::BK_IDLE:  if (item_valid) state_in = pthc_pkg::BK_ISSUE;
         pthc_pkg::BK_ISSUE: state_in = pthc_pkg::BK_MUL;
         pthc_pkg::BK_MUL: begin
            if (mul_done) begin
               if (step_ff == pthc_pkg::P_NUM) begin
                  state_in = pthc_pkg::BK_DIV;
               end else if (step_ff == pthc_pkg::H_R) begin
                  state_in = pthc_pkg::BK_PUSH;
               end else begin
                  state_in = pthc_pkg::BK_ISSUE;
               end
            end
         end
         pthc_pkg::BK_DIV:   if (div_done) state_in = pthc_pkg::BK_ISSUE;
         pthc_pkg::BK_PUSH:  if (out_free) state_in = pthc_pkg::BK_IDLE;
         default:            state_in = pthc_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      psum = pp_ff + pa_ff + pb_ff;
      pfin = ($signed(psum) >>> 8) + {{44{cfg.p7[15]}}, cfg.p7, 4'd0};
      tc = $signed({tf_ff[29:0], 2'd0} + tf_ff + pthc_pkg::TEMP_ROUND) >>> 8;
      if (hv_ff[31]) begin
         hclamp = 32'd0;
      end else if (hv_ff > pthc_pkg::HUM_LIMIT) begin
         hclamp = pthc_pkg::HUM_LIMIT;
      end else begin
         hclamp = hv_ff;
      end
   end

   always_comb begin
      item_pop = 1'b0;
      step_in = step_ff;
      item_in = item_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      v1_in = v1_ff; dd_in = dd_ff; tf_in = tf_ff;
      xx_in = xx_ff; w2_in = w2_ff; w1_in = w1_ff;
      pp_in = pp_ff; sq_in = sq_ff; pa_in = pa_ff; pb_in = pb_ff; pv_in = pv_ff;
      ha_in = ha_ff; hb_in = hb_ff; hc_in = hc_ff; he_in = he_ff;
      hf_in = hf_ff; hv_in = hv_ff; hs_in = hs_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         pthc_pkg::BK_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in = item_data;
               step_in = pthc_pkg::T_V1;
            end
         end
         pthc_pkg::BK_MUL: begin
            if (mul_done) begin
               step_in = pthc_pkg::step_type'(step_ff + 5'd1);
               case (step_ff)
                  pthc_pkg::T_V1:  v1_in = $signed(m32) >>> 11;
                  pthc_pkg::T_DD:  dd_in = $signed(m32) >>> 12;
                  pthc_pkg::T_V2:  tf_in = v1_ff + 32'($signed(m32) >>> 14);
                  pthc_pkg::P_XX:  xx_in = mul_res;
                  pthc_pkg::P_W2A: w2_in = mul_res;
                  pthc_pkg::P_W2B: w2_in = w2_ff + {mul_res[46:0], 17'd0}
                                          + {{13{cfg.p4[15]}}, cfg.p4, 35'd0};
                  pthc_pkg::P_W1A: w1_in = $signed(mul_res) >>> 8;
                  pthc_pkg::P_W1B: w1_in = w1_ff + {mul_res[51:0], 12'd0};
                  pthc_pkg::P_W1C: begin
                     w1_in = w1_new;
                     pv_in = (w1_new != 64'd0);
                     step_in = (w1_new != 64'd0) ? pthc_pkg::P_NUM : pthc_pkg::H_A;
                  end
                  pthc_pkg::P_NUM: step_in = pthc_pkg::P_A1;
                  pthc_pkg::P_A1:  sq_in = mul_res;
                  pthc_pkg::P_A2:  pa_in = $signed(mul_res) >>> 25;
                  pthc_pkg::P_B:   pb_in = $signed(mul_res) >>> 19;
                  pthc_pkg::H_A:   ha_in = $signed({item_ff.raw_humidity, 14'd0}
                                          - {cfg.h4[11:0], 20'd0} - m32
                                          + pthc_pkg::HUM_ROUND_A) >>> 15;
                  pthc_pkg::H_B:   hb_in = $signed(m32) >>> 10;
                  pthc_pkg::H_C:   hc_in = 32'($signed(m32) >>> 11) + pthc_pkg::HUM_BIAS_C;
                  pthc_pkg::H_E:   he_in = 32'($signed(m32) >>> 10) + pthc_pkg::HUM_BIAS_E;
                  pthc_pkg::H_F:   hf_in = $signed(m32 + pthc_pkg::HUM_ROUND_F) >>> 14;
                  pthc_pkg::H_V:   hv_in = m32;
                  pthc_pkg::H_S:   hs_in = $signed(m32) >>> 7;
                  pthc_pkg::H_R:   hv_in = hv_ff - 32'($signed(m32) >>> 4);
                  default:         step_in = step_ff;
               endcase
            end
         end
         pthc_pkg::BK_DIV: begin
            if (div_done) begin
               pp_in = div_q;
            end
         end
         pthc_pkg::BK_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.temperature_centi = tc;
               rsp_in.fine_temperature = tf_ff;
               rsp_in.pressure_q24_8 = pv_ff ? pfin[31:0] : 32'd0;
               rsp_in.pressure_valid = pv_ff;
               rsp_in.humidity_q22_10 = hclamp[28:12];
            end
         end
         default: item_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pthc_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      item_ff <= item_in;
      rsp_ff <= rsp_in;
      v1_ff <= v1_in; dd_ff <= dd_in; tf_ff <= tf_in;
      xx_ff <= xx_in; w2_ff <= w2_in; w1_ff <= w1_in;
      pp_ff <= pp_in; sq_ff <= sq_in; pa_ff <= pa_in; pb_ff <= pb_in; pv_ff <= pv_in;
      ha_ff <= ha_in; hb_ff <= hb_in; hc_ff <= hc_in; he_ff <= he_in;
      hf_ff <= hf_in; hv_ff <= hv_in; hs_ff <= hs_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

### hdl/pth_sensor_compensation_core.sv
`timescale 1ns / 1ps
// Top level of the pressure/temperature/humidity compensation core.
// Depends on pthc_pkg, pthc_front and pthc_back.
//
// Each raw sample beat yields one compensated beat: temperature in 0.01 degC
// with the fine temperature term, pressure in Q24.8 Pa and humidity in Q22.10 %RH.
// The work per item is set by the single shared 32 x 32 multiplier (21 products
// in turn) and the bit-serial divider; the divider and the later pressure products
// are skipped when the pressure divisor is zero. Two beats can queue up while one
// is computed; a finished beat waits in the output register. The user must write
// calibration through the csr port while the core is idle; it is not enforced.
module pth_sensor_compensation_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pthc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pthc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [pthc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pthc_pkg::CSR_DATA_W-1:0]    csr_data
);

   pthc_pkg::cfg_type cfg;
   pthc_pkg::req_type item_data;
   logic              item_valid;
   logic              item_pop;

   pthc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .cfg(cfg), .item_valid(item_valid), .item_data(item_data), .item_pop(item_pop)
   );

   pthc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .item_valid(item_valid), .item_data(item_data), .item_pop(item_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   a_invalid_pressure_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pressure_valid |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("pressure nonzero on a beat flagged invalid");

   a_humidity_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_q22_10 <= 17'd102400)
      else $error("humidity above full scale");

   a_pop_only_when_queued: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("back end took an item from an empty queue");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

endmodule
